[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/uf_pkg.sv]
package uf_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LABEL_W      = 11;
    localparam int RANK_W       = 4;

    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;
    localparam logic [LABEL_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(MAX_ELEMENTS - 1);

    localparam logic FUNC_UNION = 1'b0;
    localparam logic FUNC_FIND  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [LABEL_W-1:0] first_element;
        logic [LABEL_W-1:0] second_element;
    } t_request;

    typedef struct packed {
        logic [LABEL_W-1:0] root_label;
        logic               merged;
        logic               range_error;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              par_we;
        logic [IDX_W-1:0]  par_addr;
        logic [IDX_W-1:0]  par_data;
        logic              rank_we;
        logic [IDX_W-1:0]  rank_addr;
        logic [RANK_W-1:0] rank_data;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_START_B,
        ST_WALK_B,
        ST_RANK_A,
        ST_RANK_B,
        ST_LINK
    } t_state;

    function automatic logic [LABEL_W-1:0] to_label(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        t = 32'(idx) + 32'd1;
        return t[LABEL_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_index(input logic [LABEL_W-1:0] label);
        logic [31:0] t;
        t = 32'(label) - 32'd1;
        return t[IDX_W-1:0];
    endfunction

endpackage

[rtl/uf_ram.sv]
module uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/uf_seq.sv]
module uf_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  uf_pkg::t_request            i_request,
    input  logic [uf_pkg::LABEL_W-1:0]  i_count,
    input  logic [uf_pkg::IDX_W-1:0]    i_par_rdata,
    input  logic [uf_pkg::RANK_W-1:0]   i_rank_rdata,
    output logic                        o_busy,
    output logic                        o_done,
    output uf_pkg::t_result             o_result,
    output uf_pkg::t_mem_req            o_mem
);

    uf_pkg::t_state r_state, n_state;

    logic [uf_pkg::IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [uf_pkg::IDX_W-1:0]  r_cur, n_cur;
    logic [uf_pkg::IDX_W-1:0]  r_steps, n_steps;
    logic                      r_func, n_func;
    logic [uf_pkg::IDX_W-1:0]  r_a_idx, n_a_idx;
    logic [uf_pkg::IDX_W-1:0]  r_b_idx, n_b_idx;
    logic [uf_pkg::IDX_W-1:0]  r_root_a, n_root_a;
    logic [uf_pkg::IDX_W-1:0]  r_root_b, n_root_b;
    logic [uf_pkg::RANK_W-1:0] r_rank_a, n_rank_a;
    logic                      r_done, n_done;
    uf_pkg::t_result           r_result, n_result;

    logic [31:0]               eff_count;
    logic                      bad_a;
    logic                      bad_b;
    logic                      req_err;
    logic                      at_root;
    logic                      walk_end;
    logic [uf_pkg::IDX_W-1:0]  walk_root;

    always_comb begin
        eff_count = (32'(i_count) > 32'(uf_pkg::MAX_ELEMENTS)) ?
                    32'(uf_pkg::MAX_ELEMENTS) : 32'(i_count);
        bad_a = (i_request.first_element == '0) ||
                (32'(i_request.first_element) > eff_count);
        bad_b = (i_request.second_element == '0) ||
                (32'(i_request.second_element) > eff_count);
        req_err = bad_a || ((i_request.func == uf_pkg::FUNC_UNION) && bad_b);
    end

    assign at_root   = (i_par_rdata == r_cur);
    assign walk_end  = at_root || (r_steps == uf_pkg::IDX_LAST);
    assign walk_root = at_root ? r_cur : i_par_rdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            uf_pkg::ST_CLEAR: begin
                if (r_clr_idx == uf_pkg::IDX_LAST) begin
                    n_state = uf_pkg::ST_IDLE;
                end
            end
            uf_pkg::ST_IDLE: begin
                if (i_start && !req_err) begin
                    n_state = uf_pkg::ST_WALK_A;
                end
            end
            uf_pkg::ST_WALK_A: begin
                if (walk_end) begin
                    n_state = (r_func == uf_pkg::FUNC_FIND) ? uf_pkg::ST_IDLE
                                                             : uf_pkg::ST_START_B;
                end
            end
            uf_pkg::ST_START_B: n_state = uf_pkg::ST_WALK_B;
            uf_pkg::ST_WALK_B: begin
                if (walk_end) begin
                    n_state = (walk_root == r_root_a) ? uf_pkg::ST_IDLE
                                                      : uf_pkg::ST_RANK_A;
                end
            end
            uf_pkg::ST_RANK_A: n_state = uf_pkg::ST_RANK_B;
            uf_pkg::ST_RANK_B: n_state = uf_pkg::ST_LINK;
            uf_pkg::ST_LINK:   n_state = uf_pkg::ST_IDLE;
            default:           n_state = uf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr_idx = r_clr_idx;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_func    = r_func;
        n_a_idx   = r_a_idx;
        n_b_idx   = r_b_idx;
        n_root_a  = r_root_a;
        n_root_b  = r_root_b;
        n_rank_a  = r_rank_a;
        n_done    = 1'b0;
        n_result  = r_result;
        o_mem     = '0;
        case (r_state)
            uf_pkg::ST_CLEAR: begin
                o_mem.par_we    = 1'b1;
                o_mem.par_addr  = r_clr_idx;
                o_mem.par_data  = r_clr_idx;
                o_mem.rank_we   = 1'b1;
                o_mem.rank_addr = r_clr_idx;
                o_mem.rank_data = '0;
                n_clr_idx       = r_clr_idx + 1'b1;
            end
            uf_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (req_err) begin
                        n_done   = 1'b1;
                        n_result = '{root_label: '0, merged: 1'b0, range_error: 1'b1};
                    end else begin
                        n_func        = i_request.func;
                        n_a_idx       = uf_pkg::to_index(i_request.first_element);
                        n_b_idx       = uf_pkg::to_index(i_request.second_element);
                        n_cur         = uf_pkg::to_index(i_request.first_element);
                        n_steps       = '0;
                        o_mem.rd_addr = uf_pkg::to_index(i_request.first_element);
                    end
                end
            end
            uf_pkg::ST_WALK_A: begin
                if (walk_end) begin
                    o_mem.par_we   = 1'b1;
                    o_mem.par_addr = r_a_idx;
                    o_mem.par_data = walk_root;
                    n_root_a       = walk_root;
                    if (r_func == uf_pkg::FUNC_FIND) begin
                        n_done   = 1'b1;
                        n_result = '{root_label: uf_pkg::to_label(walk_root),
                                     merged: 1'b0, range_error: 1'b0};
                    end
                end else begin
                    n_cur         = i_par_rdata;
                    n_steps       = r_steps + 1'b1;
                    o_mem.rd_addr = i_par_rdata;
                end
            end
            uf_pkg::ST_START_B: begin
                o_mem.rd_addr = r_b_idx;
                n_cur         = r_b_idx;
                n_steps       = '0;
            end
            uf_pkg::ST_WALK_B: begin
                if (walk_end) begin
                    o_mem.par_we   = 1'b1;
                    o_mem.par_addr = r_b_idx;
                    o_mem.par_data = walk_root;
                    n_root_b       = walk_root;
                    if (walk_root == r_root_a) begin
                        n_done   = 1'b1;
                        n_result = '{root_label: uf_pkg::to_label(walk_root),
                                     merged: 1'b0, range_error: 1'b0};
                    end
                end else begin
                    n_cur         = i_par_rdata;
                    n_steps       = r_steps + 1'b1;
                    o_mem.rd_addr = i_par_rdata;
                end
            end
            uf_pkg::ST_RANK_A: begin
                o_mem.rd_addr = r_root_a;
            end
            uf_pkg::ST_RANK_B: begin
                n_rank_a      = i_rank_rdata;
                o_mem.rd_addr = r_root_b;
            end
            uf_pkg::ST_LINK: begin
                n_done = 1'b1;
                o_mem.par_we = 1'b1;
                if (r_rank_a > i_rank_rdata) begin
                    o_mem.par_addr = r_root_b;
                    o_mem.par_data = r_root_a;
                    n_result = '{root_label: uf_pkg::to_label(r_root_a),
                                 merged: 1'b1, range_error: 1'b0};
                end else begin
                    o_mem.par_addr = r_root_a;
                    o_mem.par_data = r_root_b;
                    if ((r_rank_a == i_rank_rdata) && (i_rank_rdata != uf_pkg::RANK_MAX)) begin
                        o_mem.rank_we   = 1'b1;
                        o_mem.rank_addr = r_root_b;
                        o_mem.rank_data = i_rank_rdata + 1'b1;
                    end
                    n_result = '{root_label: uf_pkg::to_label(r_root_b),
                                 merged: 1'b1, range_error: 1'b0};
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= uf_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_func   <= n_func;
        r_a_idx  <= n_a_idx;
        r_b_idx  <= n_b_idx;
        r_root_a <= n_root_a;
        r_root_b <= n_root_b;
        r_rank_a <= n_rank_a;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != uf_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/union_find_by_rank_unit.sv]
// Channel   Ports                              Handshake
// request   i_request (t_request)              start high while busy low
// result    o_result (t_result)                o_done high for one cycle
// config    i_cfg_wdata (element count)        i_cfg_we high, taken at once
//
// After reset the unit sweeps both tables with busy high.
// A find walks one tree; a union walks both and, if the roots differ, reads
// both ranks and links them; each walk step is one read of the parent memory.
// A rejected label returns its result in the cycle after the request.
// The result strobe is never held off, and a new request may be taken in the
// cycle that carries the previous result.

`include "assert_macros.svh"

module union_find_by_rank_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  uf_pkg::t_request            i_request,
    output logic                        o_done,
    output uf_pkg::t_result             o_result,
    input  logic                        i_cfg_we,
    input  logic [uf_pkg::LABEL_W-1:0]  i_cfg_wdata
);

    logic [uf_pkg::LABEL_W-1:0] r_element_count;
    uf_pkg::t_mem_req           mem_req;
    logic [uf_pkg::IDX_W-1:0]   par_rdata;
    logic [uf_pkg::RANK_W-1:0]  rank_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= uf_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_element_count <= i_cfg_wdata;
        end
    end

    uf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_request    (i_request),
        .i_count      (r_element_count),
        .i_par_rdata  (par_rdata),
        .i_rank_rdata (rank_rdata),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_mem        (mem_req)
    );

    uf_ram #(
        .WIDTH (uf_pkg::IDX_W),
        .DEPTH (uf_pkg::MAX_ELEMENTS)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.par_we),
        .i_waddr (mem_req.par_addr),
        .i_wdata (mem_req.par_data),
        .i_raddr (mem_req.rd_addr),
        .o_rdata (par_rdata)
    );

    uf_ram #(
        .WIDTH (uf_pkg::RANK_W),
        .DEPTH (uf_pkg::MAX_ELEMENTS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.rank_we),
        .i_waddr (mem_req.rank_addr),
        .i_wdata (mem_req.rank_data),
        .i_raddr (mem_req.rd_addr),
        .o_rdata (rank_rdata)
    );

    `ASSERT_SAME(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `ASSERT_SAME(a_err_clean, i_clk, i_rst_n, o_done && o_result.range_error,
                 (o_result.root_label == '0) && !o_result.merged)
    `ASSERT_SAME(a_done_cause, i_clk, i_rst_n, o_done, $past(busy) || $past(start))

endmodule

[sim/union_find_by_rank_unit_tb.sv]
module union_find_by_rank_unit_tb;

    localparam int MAX_ELEMENTS     = uf_pkg::MAX_ELEMENTS;
    localparam int IDX_W            = uf_pkg::IDX_W;
    localparam int LABEL_W          = uf_pkg::LABEL_W;
    localparam int RANK_W           = uf_pkg::RANK_W;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE  = 350;
    localparam int REPORT_LIMIT     = 10;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    uf_pkg::t_request   i_request   = '0;
    logic               o_done;
    uf_pkg::t_result    o_result;
    logic               i_cfg_we    = 1'b0;
    logic [LABEL_W-1:0] i_cfg_wdata = '0;

    logic [IDX_W-1:0]   forest_parent [MAX_ELEMENTS];
    logic [RANK_W-1:0]  forest_rank [MAX_ELEMENTS];
    logic [LABEL_W-1:0] element_limit;
    uf_pkg::t_result    pending_results [$];
    int                 mismatches = 0;
    int                 cycles = 0;

    union_find_by_rank_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_request   (i_request),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL union_find_by_rank_unit");
            $finish;
        end
    end

    function automatic logic [LABEL_W-1:0] usable_count();
        return (element_limit > LABEL_W'(MAX_ELEMENTS)) ? LABEL_W'(MAX_ELEMENTS)
                                                         : element_limit;
    endfunction

    // Walks to the root and points the starting node straight at it.
    function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] node);
        logic [IDX_W-1:0] cur;
        int               steps;
        cur = node;
        steps = 0;
        while (steps < MAX_ELEMENTS && forest_parent[cur] != cur) begin
            cur = forest_parent[cur];
            steps++;
        end
        forest_parent[node] = cur;
        return cur;
    endfunction

    function automatic uf_pkg::t_result resolve_request(input uf_pkg::t_request req);
        uf_pkg::t_result    res;
        logic [LABEL_W-1:0] cnt;
        logic               bad_first;
        logic               bad_second;
        logic [IDX_W-1:0]   root_a;
        logic [IDX_W-1:0]   root_b;
        logic [IDX_W-1:0]   root;
        res = '0;
        cnt = usable_count();
        bad_first = (req.first_element == '0) || (req.first_element > cnt);
        bad_second = (req.second_element == '0) || (req.second_element > cnt);
        if (bad_first || (req.func == uf_pkg::FUNC_UNION && bad_second)) begin
            res.range_error = 1'b1;
            return res;
        end
        root_a = find_root(IDX_W'(req.first_element - LABEL_W'(1)));
        root = root_a;
        if (req.func == uf_pkg::FUNC_UNION) begin
            root_b = find_root(IDX_W'(req.second_element - LABEL_W'(1)));
            if (root_a != root_b) begin
                res.merged = 1'b1;
                if (forest_rank[root_a] > forest_rank[root_b]) begin
                    forest_parent[root_b] = root_a;
                end else begin
                    forest_parent[root_a] = root_b;
                    if (forest_rank[root_a] == forest_rank[root_b] &&
                        forest_rank[root_b] < uf_pkg::RANK_MAX) begin
                        forest_rank[root_b] = forest_rank[root_b] + RANK_W'(1);
                    end
                    root = root_b;
                end
            end
        end
        res.root_label = LABEL_W'(root) + LABEL_W'(1);
        return res;
    endfunction

    function automatic uf_pkg::t_request make_request(input logic func,
                                                      input int first, input int second);
        uf_pkg::t_request req;
        req.func = func;
        req.first_element = LABEL_W'(first);
        req.second_element = LABEL_W'(second);
        return req;
    endfunction

    function automatic uf_pkg::t_request random_request();
        uf_pkg::t_request   req;
        logic [LABEL_W-1:0] cnt;
        cnt = usable_count();
        req.func = ($urandom_range(0, 9) < 6) ? uf_pkg::FUNC_UNION : uf_pkg::FUNC_FIND;
        req.first_element = LABEL_W'($urandom_range(0, 2047));
        req.second_element = LABEL_W'($urandom_range(0, 2047));
        if (cnt != '0 && $urandom_range(0, 9) != 0) begin
            req.first_element = LABEL_W'($urandom_range(1, cnt));
            if (req.func == uf_pkg::FUNC_UNION) begin
                req.second_element = LABEL_W'($urandom_range(1, cnt));
            end
        end
        return req;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        uf_pkg::t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result root=%0d merged=%b err=%b",
                              o_result.root_label, o_result.merged,
                              o_result.range_error));
            end else begin
                want = pending_results.pop_front();
                if (o_result.root_label !== want.root_label ||
                    o_result.merged !== want.merged ||
                    o_result.range_error !== want.range_error) begin
                    flag_mismatch($sformatf({"expected root=%0d merged=%b err=%b, ",
                                  "got root=%0d merged=%b err=%b"},
                                  want.root_label, want.merged, want.range_error,
                                  o_result.root_label, o_result.merged,
                                  o_result.range_error));
                end
            end
        end
    end

    // Leaves start high so that a following request can go out back to back.
    task automatic send_request(input uf_pkg::t_request req);
        uf_pkg::t_result expected;
        i_request <= req;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected = resolve_request(req);
        pending_results = {pending_results, expected};
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic write_count(input int value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= LABEL_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        element_limit = LABEL_W'(value);
    endtask

    task automatic test_basic_operations();
        write_count(MAX_ELEMENTS);
        send_request(make_request(uf_pkg::FUNC_FIND, 1, 1));
        send_request(make_request(uf_pkg::FUNC_FIND, 1024, 0));
        send_request(make_request(uf_pkg::FUNC_FIND, 0, 5));
        send_request(make_request(uf_pkg::FUNC_FIND, 1025, 1));
        send_request(make_request(uf_pkg::FUNC_FIND, 2047, 2047));
        send_request(make_request(uf_pkg::FUNC_UNION, 1, 2));
        send_request(make_request(uf_pkg::FUNC_UNION, 2, 1));
        send_request(make_request(uf_pkg::FUNC_UNION, 3, 4));
        send_request(make_request(uf_pkg::FUNC_UNION, 1, 3));
        send_request(make_request(uf_pkg::FUNC_FIND, 1, 2047));
        send_request(make_request(uf_pkg::FUNC_UNION, 5, 5));
        send_request(make_request(uf_pkg::FUNC_UNION, 1, 0));
        send_request(make_request(uf_pkg::FUNC_UNION, 0, 1));
        send_request(make_request(uf_pkg::FUNC_UNION, 1024, 1025));
        send_request(make_request(uf_pkg::FUNC_FIND, 3, 0));
        send_request(make_request(uf_pkg::FUNC_UNION, 6, 1));
        send_request(make_request(uf_pkg::FUNC_UNION, 1024, 1023));
    endtask

    task automatic test_count_extremes();
        write_count(1);
        send_request(make_request(uf_pkg::FUNC_FIND, 1, 1));
        send_request(make_request(uf_pkg::FUNC_FIND, 2, 1));
        send_request(make_request(uf_pkg::FUNC_UNION, 1, 1));
        write_count(0);
        send_request(make_request(uf_pkg::FUNC_FIND, 1, 1));
        send_request(make_request(uf_pkg::FUNC_UNION, 1, 1));
        write_count(2047);
        send_request(make_request(uf_pkg::FUNC_FIND, 1024, 3));
        send_request(make_request(uf_pkg::FUNC_FIND, 1025, 3));
        // The root of elements one to four lies above the lowered count.
        write_count(3);
        send_request(make_request(uf_pkg::FUNC_FIND, 1, 0));
        send_request(make_request(uf_pkg::FUNC_UNION, 2, 3));
    endtask

    task automatic run_traffic_phase(input int count, input int items);
        int sent;
        int burst;
        write_count(count);
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < items; k++) begin
                send_request(random_request());
                sent++;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(16, ITEMS_PER_PHASE);
        run_traffic_phase(MAX_ELEMENTS, ITEMS_PER_PHASE);
        run_traffic_phase($urandom_range(100, 600), ITEMS_PER_PHASE);
        run_traffic_phase(2047, ITEMS_PER_PHASE);
        run_traffic_phase(64, ITEMS_PER_PHASE);
    endtask

    initial begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            forest_parent[i] = IDX_W'(i);
            forest_rank[i] = '0;
        end
        element_limit = uf_pkg::COUNT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_operations();
        test_count_extremes();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS union_find_by_rank_unit");
        end else begin
            $display("FAIL union_find_by_rank_unit");
        end
        $finish;
    end

endmodule
